[rtl/ttcw_pkg.sv]
// Shared constants, types and helpers of the text terminal cell writer.
package ttcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = CELL_COUNT - COLUMNS;

    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int IDX_W     = $clog2(CELL_COUNT + 1);
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int MODE_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int POS_W     = 11;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET    = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'h0;
    localparam logic [CELL_W-1:0]  RESET_BLANK = {BG_RESET, FG_RESET, CHAR_SPACE};

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 3'd0,
        MODE_ERASE = 3'd1,
        MODE_SET   = 3'd2,
        MODE_CLEAR = 3'd3,
        MODE_READ  = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOREGROUND = 1'b0,
        CFG_BACKGROUND = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Linear cell index of an in-range row and column.
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

[rtl/ttcw_channels.sv]
// Channel interfaces: command input, result output and register write.
interface ttcw_in_if;
    logic                           valid;
    logic                           ready;
    logic [ttcw_pkg::MODE_W-1:0]    mode;
    logic [ttcw_pkg::CHAR_W-1:0]    char_code;
    logic [ttcw_pkg::COL_W-1:0]     target_column;
    logic [ttcw_pkg::ROW_W-1:0]     target_row;

    modport source (output valid, output mode, output char_code, output target_column,
                    output target_row, input ready);
    modport sink   (input valid, input mode, input char_code, input target_column,
                    input target_row, output ready);
endinterface

interface ttcw_out_if;
    logic                           valid;
    logic                           ready;
    logic [ttcw_pkg::POS_W-1:0]     cursor_position;
    logic [ttcw_pkg::CELL_W-1:0]    cell_data;
    logic                           echo_valid;
    logic [ttcw_pkg::CHAR_W-1:0]    echo_char;

    modport source (output valid, output cursor_position, output cell_data,
                    output echo_valid, output echo_char, input ready);
    modport sink   (input valid, input cursor_position, input cell_data,
                    input echo_valid, input echo_char, output ready);
endinterface

interface ttcw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ttcw_pkg::CFG_IDX_W-1:0] index;
    logic [ttcw_pkg::COLOR_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/text_terminal_cell_writer_core.sv]
// Top level of the text terminal cell writer: color registers, sequencer and cell store.
//
//  Channel  Port    Dir  Contents
//  command  i_in    in   mode, char_code, target_column, target_row
//  result   o_res   out  cursor_position, cell_data, echo_valid, echo_char
//  config   i_cfg   in   index (0 foreground, 1 background), data (4-bit color)
//
// In ordinary commands the transfer cycle does the cell write or read, and the result
// register is loaded in the emit state once it is free.
// A scroll and a clear sweep every cell; both are bound by the single write port
// of the cell store.
// After reset a clearing pass blanks every cell of the store; no command is taken
// meanwhile, configuration writes are.
// A stalled result holds in its register; one more command is still taken and carried
// out, and then its result waits until the register is free.
module text_terminal_cell_writer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttcw_in_if.sink       i_in,
    ttcw_out_if.source    o_res,
    ttcw_cfg_if.sink      i_cfg
);

    logic [ttcw_pkg::COLOR_W-1:0] r_fg;
    logic [ttcw_pkg::COLOR_W-1:0] r_bg;
    ttcw_pkg::t_ram_req           ram_req;
    logic [ttcw_pkg::CELL_W-1:0]  ram_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= ttcw_pkg::FG_RESET;
            r_bg <= ttcw_pkg::BG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (ttcw_pkg::t_cfg_reg'(i_cfg.index))
                ttcw_pkg::CFG_FOREGROUND: r_fg <= i_cfg.data;
                ttcw_pkg::CFG_BACKGROUND: r_bg <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    ttcw_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (o_res),
        .i_attr      ({r_bg, r_fg}),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    ttcw_cell_ram u_cell_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

[rtl/ttcw_cell_ram.sv]
// Character cell store: one write port and one registered read port.
module ttcw_cell_ram (
    input  logic                          i_clk,
    input  ttcw_pkg::t_ram_req            i_req,
    output logic [ttcw_pkg::CELL_W-1:0]   o_rdata
);

    logic [ttcw_pkg::CELL_W-1:0] r_mem [ttcw_pkg::CELL_COUNT];
    logic [ttcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ttcw_engine.sv]
// Command sequencer: cursor update, cell writes, scroll and fill sweeps, result register.
module ttcw_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ttcw_in_if.sink                       i_in,
    ttcw_out_if.source                    o_res,
    input  logic [ttcw_pkg::ATTR_W-1:0]   i_attr,
    output ttcw_pkg::t_ram_req            o_ram_req,
    input  logic [ttcw_pkg::CELL_W-1:0]   i_ram_rdata
);

    ttcw_pkg::t_state r_state, n_state;
    logic [ttcw_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [ttcw_pkg::COL_W-1:0]  r_col;
    logic [ttcw_pkg::ROW_W-1:0]  r_row;
    logic                        r_put;
    logic [ttcw_pkg::CHAR_W-1:0] r_char;
    logic                        r_read_ok;
    logic                        r_out_valid, n_out_valid;
    logic [ttcw_pkg::POS_W-1:0]  r_out_pos;
    logic [ttcw_pkg::CELL_W-1:0] r_out_cell;
    logic                        r_out_echo;
    logic [ttcw_pkg::CHAR_W-1:0] r_out_char;

    logic                        accept;
    logic                        emit;
    logic [ttcw_pkg::CELL_W-1:0] blank;

    // Decoded command
    logic [ttcw_pkg::COL_W:0]    c_col_inc;
    logic [ttcw_pkg::COL_W:0]    c_tab;
    logic [ttcw_pkg::ROW_W:0]    c_row_inc;
    logic [ttcw_pkg::COL_W-1:0]  c_col;
    logic [ttcw_pkg::ROW_W:0]    c_row_w;
    logic [ttcw_pkg::ROW_W-1:0]  c_row;
    logic                        c_scroll;
    logic                        c_clear;
    logic                        c_we;
    logic [ttcw_pkg::COL_W-1:0]  c_wcol;
    logic [ttcw_pkg::ROW_W-1:0]  c_wrow;
    logic [ttcw_pkg::CHAR_W-1:0] c_wchar;
    logic                        c_read_ok;

    assign accept = i_in.valid && i_in.ready;
    assign emit   = (r_state == ttcw_pkg::ST_EMIT) && (!r_out_valid || o_res.ready);
    assign blank  = {i_attr, ttcw_pkg::CHAR_SPACE};

    always_comb begin
        c_col_inc = (ttcw_pkg::COL_W + 1)'(r_col) + (ttcw_pkg::COL_W + 1)'(1);
        c_tab     = ((ttcw_pkg::COL_W + 1)'(r_col) + (ttcw_pkg::COL_W + 1)'(4))
                    & ~(ttcw_pkg::COL_W + 1)'(3);
        c_row_inc = (ttcw_pkg::ROW_W + 1)'(r_row) + (ttcw_pkg::ROW_W + 1)'(1);
        c_col     = r_col;
        c_row_w   = (ttcw_pkg::ROW_W + 1)'(r_row);
        c_clear   = 1'b0;
        c_we      = 1'b0;
        c_wcol    = r_col;
        c_wrow    = r_row;
        c_wchar   = ttcw_pkg::CHAR_SPACE;
        unique case (ttcw_pkg::t_mode'(i_in.mode))
            ttcw_pkg::MODE_PUT: begin
                case (i_in.char_code)
                    ttcw_pkg::CHAR_LF: begin
                        c_col   = '0;
                        c_row_w = c_row_inc;
                    end
                    ttcw_pkg::CHAR_CR: begin
                        c_col = '0;
                    end
                    ttcw_pkg::CHAR_TAB: begin
                        if (c_tab >= (ttcw_pkg::COL_W + 1)'(ttcw_pkg::COLUMNS)) begin
                            c_col   = '0;
                            c_row_w = c_row_inc;
                        end else begin
                            c_col = ttcw_pkg::COL_W'(c_tab);
                        end
                    end
                    ttcw_pkg::CHAR_BS: begin
                        // Backspace stops at the left edge and never wraps.
                        if (r_col != '0) begin
                            c_col  = r_col - ttcw_pkg::COL_W'(1);
                            c_we   = 1'b1;
                            c_wcol = r_col - ttcw_pkg::COL_W'(1);
                        end
                    end
                    default: begin
                        c_we    = 1'b1;
                        c_wchar = i_in.char_code;
                        if (c_col_inc >= (ttcw_pkg::COL_W + 1)'(ttcw_pkg::COLUMNS)) begin
                            c_col   = '0;
                            c_row_w = c_row_inc;
                        end else begin
                            c_col = ttcw_pkg::COL_W'(c_col_inc);
                        end
                    end
                endcase
            end
            ttcw_pkg::MODE_ERASE: begin
                // At the origin the cursor stays put and cell zero is blanked.
                c_we = 1'b1;
                if (r_col != '0) begin
                    c_col  = r_col - ttcw_pkg::COL_W'(1);
                    c_wcol = r_col - ttcw_pkg::COL_W'(1);
                end else if (r_row != '0) begin
                    c_col   = ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS - 1);
                    c_row_w = (ttcw_pkg::ROW_W + 1)'(r_row - ttcw_pkg::ROW_W'(1));
                    c_wcol  = ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS - 1);
                    c_wrow  = r_row - ttcw_pkg::ROW_W'(1);
                end
            end
            ttcw_pkg::MODE_SET: begin
                if (i_in.target_column < ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS)) begin
                    c_col = i_in.target_column;
                end
                if (i_in.target_row < ttcw_pkg::ROW_W'(ttcw_pkg::ROWS)) begin
                    c_row_w = (ttcw_pkg::ROW_W + 1)'(i_in.target_row);
                end
            end
            ttcw_pkg::MODE_CLEAR: begin
                c_clear = 1'b1;
                c_col   = '0;
                c_row_w = '0;
            end
            ttcw_pkg::MODE_READ: begin
            end
            default: begin
            end
        endcase
        c_scroll  = c_row_w >= (ttcw_pkg::ROW_W + 1)'(ttcw_pkg::ROWS);
        c_row     = c_scroll ? ttcw_pkg::ROW_W'(ttcw_pkg::ROWS - 1) : ttcw_pkg::ROW_W'(c_row_w);
        c_read_ok = (ttcw_pkg::t_mode'(i_in.mode) == ttcw_pkg::MODE_READ)
                    && (i_in.target_column < ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS))
                    && (i_in.target_row < ttcw_pkg::ROW_W'(ttcw_pkg::ROWS));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttcw_pkg::ST_INIT: begin
                if (r_idx == ttcw_pkg::IDX_W'(ttcw_pkg::CELL_COUNT - 1)) begin
                    n_state = ttcw_pkg::ST_IDLE;
                end
            end
            ttcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (c_clear) begin
                        n_state = ttcw_pkg::ST_FILL;
                    end else if (c_scroll) begin
                        n_state = ttcw_pkg::ST_SCROLL;
                    end else begin
                        n_state = ttcw_pkg::ST_EMIT;
                    end
                end
            end
            ttcw_pkg::ST_SCROLL: begin
                if (r_idx == ttcw_pkg::IDX_W'(ttcw_pkg::CELL_COUNT)) begin
                    n_state = ttcw_pkg::ST_EMIT;
                end
            end
            ttcw_pkg::ST_FILL: begin
                if (r_idx == ttcw_pkg::IDX_W'(ttcw_pkg::CELL_COUNT - 1)) begin
                    n_state = ttcw_pkg::ST_EMIT;
                end
            end
            ttcw_pkg::ST_EMIT: begin
                if (emit) begin
                    n_state = ttcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttcw_pkg::ST_INIT;
            end
        endcase
    end

    // Outputs: memory requests, sweep counter and handshakes
    always_comb begin
        o_ram_req = '0;
        n_idx     = '0;
        unique case (r_state)
            ttcw_pkg::ST_INIT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = ttcw_pkg::ADDR_W'(r_idx);
                o_ram_req.wdata = ttcw_pkg::RESET_BLANK;
                n_idx           = r_idx + ttcw_pkg::IDX_W'(1);
            end
            ttcw_pkg::ST_FILL: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = ttcw_pkg::ADDR_W'(r_idx);
                o_ram_req.wdata = blank;
                n_idx           = r_idx + ttcw_pkg::IDX_W'(1);
            end
            ttcw_pkg::ST_SCROLL: begin
                // Read one row ahead; the copy is written in the following cycle, then the
                // bottom row is blanked.
                o_ram_req.re    = r_idx < ttcw_pkg::IDX_W'(ttcw_pkg::SCROLL_CELLS);
                o_ram_req.raddr = ttcw_pkg::ADDR_W'(r_idx + ttcw_pkg::IDX_W'(ttcw_pkg::COLUMNS));
                o_ram_req.we    = r_idx != '0;
                o_ram_req.waddr = ttcw_pkg::ADDR_W'(r_idx - ttcw_pkg::IDX_W'(1));
                o_ram_req.wdata = (r_idx <= ttcw_pkg::IDX_W'(ttcw_pkg::SCROLL_CELLS))
                                  ? i_ram_rdata : blank;
                n_idx           = r_idx + ttcw_pkg::IDX_W'(1);
            end
            ttcw_pkg::ST_IDLE: begin
                o_ram_req.we    = accept && c_we;
                o_ram_req.waddr = ttcw_pkg::cell_index(c_wrow, c_wcol);
                o_ram_req.wdata = {i_attr, c_wchar};
                o_ram_req.re    = accept && c_read_ok;
                o_ram_req.raddr = ttcw_pkg::cell_index(i_in.target_row, i_in.target_column);
            end
            ttcw_pkg::ST_EMIT: begin
            end
            default: begin
            end
        endcase
        n_out_valid = emit || (r_out_valid && !o_res.ready);
    end

    assign i_in.ready = (r_state == ttcw_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttcw_pkg::ST_INIT;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_col <= c_col;
                r_row <= c_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_put     <= ttcw_pkg::t_mode'(i_in.mode) == ttcw_pkg::MODE_PUT;
            r_char    <= i_in.char_code;
            r_read_ok <= c_read_ok;
        end
        if (emit) begin
            r_out_pos  <= ttcw_pkg::POS_W'(ttcw_pkg::cell_index(r_row, r_col));
            r_out_cell <= r_read_ok ? i_ram_rdata : '0;
            r_out_echo <= r_put;
            r_out_char <= r_put ? r_char : '0;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_position = r_out_pos;
    assign o_res.cell_data       = r_out_cell;
    assign o_res.echo_valid      = r_out_echo;
    assign o_res.echo_char       = r_out_char;

endmodule

[rtl/ttcw_checker.sv]
// Port-level checks of the text terminal cell writer and their binding.
module ttcw_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttcw_in_if.sink       i_in,
    ttcw_out_if.source    o_res
);

    // One command is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("command taken in the cycle after a transfer");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.cursor_position < ttcw_pkg::POS_W'(ttcw_pkg::CELL_COUNT))
        else $error("cursor position outside the screen");

    a_echo_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.echo_valid |-> o_res.cell_data == '0)
        else $error("echoed result carries cell data");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.cursor_position)
            && $stable(o_res.cell_data) && $stable(o_res.echo_char))
        else $error("stalled result changed");

endmodule

bind text_terminal_cell_writer_core ttcw_checker u_ttcw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_res   (o_res)
);
